FILE: rtl/core/rational_arithmetic_unit_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit
// Each macro expands to a labeled concurrent assertion, or to nothing
// when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
	localparam int WORD_BITS = 32;
	localparam int MAG_W = 64;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ERR = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	typedef struct packed {
		logic start;
		logic [MAG_W-1:0] dividend;
		logic [MAG_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [MAG_W-1:0] quot;
		logic [MAG_W-1:0] rem;
	} div_rsp_t;
endpackage

FILE: rtl/core/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider
// Restoring divider, one quotient bit per cycle, 64-bit unsigned.
// ----------------------------------------------------------------------------
module rau_divider (
	input  logic clk,
	input  logic arst_n,
	input  rau_pkg::div_req_t req,
	output rau_pkg::div_rsp_t rsp
);
	import rau_pkg::*;

	logic [MAG_W-1:0] quo_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] dsr_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [MAG_W:0] trial;

	assign trial = {rem_q, quo_q[MAG_W-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[MAG_W]) begin
				rem_q <= trial[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[MAG_W-2:0], quo_q[MAG_W-1]};
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem = rem_q;
endmodule

FILE: rtl/core/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Exact add, subtract, multiply, divide and compare of two fractions.
// ----------------------------------------------------------------------------
// One transaction in, one out. Work runs on a single shared 64-bit
// restoring divider and one 32x32 multiplier, under a sequencer. A division
// runs from its start through 64 quotient bits to the done strobe. Each gcd
// step is one division. Add, subtract and compare first take the gcd of the
// denominator magnitudes in s1 Euclid steps; add, subtract, multiply and
// divide then take the gcd of the unreduced result in s2 steps, and multiply
// and divide skip the first gcd. s1 stays below about 46 and s2 below about
// 92. Zero denominators, divide by zero and invalid operations are answered
// in the cycle after acceptance.
// in_ready is high only while the sequencer is idle and the output register
// is empty.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_core_macros.svh"
module rational_arithmetic_unit_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] op,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] res_num,
	output logic [30:0] res_den,
	output logic signed [1:0] order,
	output logic [1:0] status
);
	import rau_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_G1   = 11'b00000000010, // lcm gcd of denominators
		S_G1W  = 11'b00000000100,
		S_FA   = 11'b00000001000, // fa = bd / g
		S_FB   = 11'b00000010000, // fb = ad / g
		S_M1   = 11'b00000100000, // products, one per cycle
		S_SUM  = 11'b00001000000,
		S_G2   = 11'b00010000000, // gcd of num, den
		S_RN   = 11'b00100000000, // num / g
		S_RD   = 11'b01000000000, // den / g
		S_FIN  = 11'b10000000000
	} state_t;

	state_t st_q;
	logic [2:0] op_q;
	logic an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [31:0] an_q, ad_q, bn_q, bd_q;
	logic [MAG_W-1:0] x_q, y_q, g_q, fa_q, fb_q, ta_q, tb_q, den_q, num_q;
	logic num_neg_q;
	logic [1:0] msel_q;
	logic wait_q;
	logic out_v_q;
	logic signed [31:0] rn_q;
	logic [30:0] rd_q;
	logic signed [1:0] ord_q;
	logic [1:0] sts_q;

	div_req_t dreq;
	div_rsp_t drsp;

	rau_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	// multiply and divide form num and den directly from the operands
	logic prod_op;
	assign prod_op = (op_q == OP_MUL) || (op_q == OP_DIV);

	// shared multiplier: 32x32 operands chosen by msel_q
	// msel 0 -> den, 1 -> scaled a numerator, 2 -> scaled b numerator (zero for mul/div)
	logic [31:0] mul_a, mul_b;
	logic [MAG_W-1:0] mul_p;
	always_comb begin
		unique case (msel_q)
			2'd0: begin
				if (prod_op) begin
					mul_a = ad_q; mul_b = (op_q == OP_MUL) ? bd_q : bn_q;
				end else begin
					mul_a = fa_q[31:0]; mul_b = ad_q;
				end
			end
			2'd1: begin
				if (prod_op) begin
					mul_a = an_q; mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
				end else begin
					mul_a = fa_q[31:0]; mul_b = an_q;
				end
			end
			2'd2: begin
				if (prod_op) begin
					mul_a = 32'd0; mul_b = 32'd0;
				end else begin
					mul_a = fb_q[31:0]; mul_b = bn_q;
				end
			end
			default: begin mul_a = 32'd0; mul_b = 32'd0; end
		endcase
	end
	assign mul_p = MAG_W'(mul_a) * MAG_W'(mul_b);

	// signed sum of the two scaled numerators
	// mul/div: tb is zero and ta carries the sign of all four operands
	logic ta_neg, tb_neg, sum_neg;
	logic [MAG_W-1:0] sum_mag;
	always_comb begin
		ta_neg = (prod_op ? (an_neg_q ^ ad_neg_q ^ bn_neg_q ^ bd_neg_q)
			: (an_neg_q != ad_neg_q)) && ta_q != '0;
		tb_neg = ((bn_neg_q != bd_neg_q) != (op_q != OP_ADD)) && tb_q != '0;
		if (ta_neg == tb_neg) begin
			sum_neg = ta_neg;
			sum_mag = ta_q + tb_q;
		end else if (ta_q >= tb_q) begin
			sum_neg = ta_neg;
			sum_mag = ta_q - tb_q;
		end else begin
			sum_neg = tb_neg;
			sum_mag = tb_q - ta_q;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
	end

	localparam logic [MAG_W-1:0] LIM = (MAG_W'(1) << (WORD_BITS - 1)) - MAG_W'(1);
	logic fits;
	assign fits = (num_neg_q ? (num_q <= LIM + MAG_W'(1)) : (num_q <= LIM)) && den_q <= LIM;

	logic [31:0] in_an, in_ad, in_bn, in_bd;
	assign in_an = mag32(a_num);
	assign in_ad = mag32(a_den);
	assign in_bn = mag32(b_num);
	assign in_bd = mag32(b_den);

	assign in_ready = (st_q == S_IDLE) && !out_v_q;

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = x_q;
		dreq.divisor = y_q;
		if (!wait_q) begin
			unique case (st_q)
				S_G1, S_G2: dreq.start = (y_q != '0);
				S_FA: begin dreq.start = 1'b1; dreq.dividend = MAG_W'(bd_q); dreq.divisor = g_q; end
				S_FB: begin dreq.start = 1'b1; dreq.dividend = MAG_W'(ad_q); dreq.divisor = g_q; end
				S_RN: begin dreq.start = 1'b1; dreq.dividend = num_q; dreq.divisor = g_q; end
				S_RD: begin dreq.start = 1'b1; dreq.dividend = den_q; dreq.divisor = g_q; end
				default: dreq.start = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			wait_q <= 1'b0;
			out_v_q <= 1'b0;
			msel_q <= 2'd0;
			x_q <= '0; y_q <= '0; g_q <= '0;
			fa_q <= '0; fb_q <= '0; ta_q <= '0; tb_q <= '0;
			den_q <= '0; num_q <= '0; num_neg_q <= 1'b0;
			rn_q <= '0; rd_q <= '0; ord_q <= '0; sts_q <= ST_OK;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			if (dreq.start) wait_q <= 1'b1;
			if (drsp.done) wait_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_valid && in_ready) begin
					if (op > OP_CMP || in_ad == 32'd0 || in_bd == 32'd0) begin
						sts_q <= ST_ERR; rn_q <= '0; rd_q <= '0; ord_q <= '0;
						out_v_q <= 1'b1;
					end else if (op == OP_DIV && in_bn == 32'd0) begin
						sts_q <= ST_ERR; rn_q <= '0; rd_q <= '0; ord_q <= '0;
						out_v_q <= 1'b1;
					end else if (op == OP_MUL || op == OP_DIV) begin
						// products straight from the operands, no lcm
						st_q <= S_M1;
						msel_q <= 2'd0;
					end else begin
						st_q <= S_G1;
						x_q <= MAG_W'(in_ad);
						y_q <= MAG_W'(in_bd);
					end
				end
				S_G1, S_G2: if (!wait_q && !dreq.start) begin
					g_q <= x_q;
					st_q <= (st_q == S_G1) ? S_FA : S_RN;
				end else if (drsp.done) begin
					x_q <= y_q;
					y_q <= drsp.rem;
				end
				S_FA: if (drsp.done) begin fa_q <= drsp.quot; st_q <= S_FB; end
				S_FB: if (drsp.done) begin
					fb_q <= drsp.quot; st_q <= S_M1; msel_q <= 2'd0;
				end
				S_M1: begin
					msel_q <= msel_q + 2'd1;
					unique case (msel_q)
						2'd0: den_q <= mul_p;
						2'd1: ta_q <= mul_p;
						2'd2: tb_q <= mul_p;
						default: st_q <= S_SUM;
					endcase
				end
				S_SUM: begin
					if (op_q == OP_CMP) begin
						rn_q <= '0; rd_q <= '0; sts_q <= ST_OK;
						ord_q <= (sum_mag == '0) ? 2'sd0 : (sum_neg ? -2'sd1 : 2'sd1);
						out_v_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						num_neg_q <= sum_neg;
						num_q <= sum_mag;
						if (sum_mag == '0) begin
							den_q <= MAG_W'(1);
							st_q <= S_FIN;
						end else begin
							x_q <= sum_mag; y_q <= den_q;
							st_q <= S_G2;
						end
					end
				end
				S_RN: if (drsp.done) begin num_q <= drsp.quot; st_q <= S_RD; end
				S_RD: if (drsp.done) begin den_q <= drsp.quot; st_q <= S_FIN; end
				S_FIN: begin
					ord_q <= '0;
					if (fits) begin
						sts_q <= ST_OK;
						rn_q <= num_neg_q ? (32'd0 - num_q[31:0]) : num_q[31:0];
						rd_q <= den_q[30:0];
					end else begin
						sts_q <= ST_OVF; rn_q <= '0; rd_q <= '0;
					end
					out_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// operand capture: magnitudes and signs
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid && in_ready) begin
			op_q <= op;
			an_q <= in_an; an_neg_q <= a_num[31];
			ad_q <= in_ad; ad_neg_q <= a_den[31];
			bn_q <= in_bn; bn_neg_q <= b_num[31];
			bd_q <= in_bd; bd_neg_q <= b_den[31];
		end
	end

	assign out_valid = out_v_q;
	assign res_num = rn_q;
	assign res_den = rd_q;
	assign order = ord_q;
	assign status = sts_q;

	`RAU_ASSERT_NXT(a_busy_blocks, clk, arst_n, in_valid && in_ready, !in_ready)
	`RAU_ASSERT_IMP(a_ord_cmp_only, clk, arst_n, out_valid && order != 2'sd0, status == ST_OK && res_den == '0)
	`RAU_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && status != ST_OK, res_num == '0 && res_den == '0)
endmodule

FILE: bench/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Watches both channels of the rational arithmetic unit, predicts each
// result from the accepted operands and compares it field by field.
// ----------------------------------------------------------------------------
module rau_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [2:0] op,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	input  logic out_valid,
	input  logic out_ready,
	input  logic signed [31:0] res_num,
	input  logic [30:0] res_den,
	input  logic signed [1:0] order,
	input  logic [1:0] status,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	typedef struct {
		logic [31:0] num;
		logic [30:0] den;
		logic [1:0] ord;
		logic [1:0] st;
	} fraction_result_t;

	fraction_result_t expected_results[$];

	function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// signed sum of sign-magnitude pairs
	function automatic void sm_add(input logic xn, input logic [63:0] xm,
			input logic yn, input logic [63:0] ym, output logic rn, output logic [63:0] rm);
		if (xn == yn) begin
			rn = xn;
			rm = xm + ym;
		end else if (xm >= ym) begin
			rn = xn;
			rm = xm - ym;
		end else begin
			rn = yn;
			rm = ym - xm;
		end
		if (rm == 0)
			rn = 1'b0;
	endfunction

	function automatic fraction_result_t predict_fraction(logic [2:0] opc,
			logic signed [31:0] an, logic signed [31:0] ad,
			logic signed [31:0] bn, logic signed [31:0] bd);
		fraction_result_t r;
		logic [63:0] anm, adm, bnm, bdm, g, fa, fb, ta, tb, num, den, lim;
		logic ann, adn, bnn, bdn, nneg, dneg, fits;
		r = '{num: '0, den: '0, ord: '0, st: ST_OK};
		ann = an[31]; adn = ad[31]; bnn = bn[31]; bdn = bd[31];
		anm = ann ? 64'(-64'(an)) : 64'(an);
		adm = adn ? 64'(-64'(ad)) : 64'(ad);
		bnm = bnn ? 64'(-64'(bn)) : 64'(bn);
		bdm = bdn ? 64'(-64'(bd)) : 64'(bd);
		nneg = 1'b0; dneg = 1'b0; num = 0; den = 1;
		if (opc > OP_CMP || adm == 0 || bdm == 0) begin
			r.st = ST_ERR;
			return r;
		end
		if (opc == OP_DIV && bnm == 0) begin
			r.st = ST_ERR;
			return r;
		end
		if (opc == OP_ADD || opc == OP_SUB || opc == OP_CMP) begin
			g = euclid_gcd(adm, bdm);
			fa = bdm / g;
			fb = adm / g;
			den = fa * adm;
			ta = anm * fa;
			tb = bnm * fb;
			sm_add((ann != adn) && ta != 0, ta,
				((bnn != bdn) != (opc != OP_ADD)) && tb != 0, tb, nneg, num);
			if (opc == OP_CMP) begin
				if (num != 0)
					r.ord = nneg ? 2'b11 : 2'b01;
				return r;
			end
		end else if (opc == OP_MUL) begin
			num = anm * bnm; nneg = ann != bnn;
			den = adm * bdm; dneg = adn != bdn;
		end else begin
			num = anm * bdm; nneg = ann != bdn;
			den = adm * bnm; dneg = adn != bnn;
		end
		if (dneg)
			nneg = !nneg;
		if (num == 0) begin
			nneg = 1'b0;
			den = 1;
		end else begin
			g = euclid_gcd(num, den);
			num = num / g;
			den = den / g;
		end
		lim = (64'd1 << (WORD_BITS - 1)) - 1;
		fits = (nneg ? num <= lim + 1 : num <= lim) && den <= lim;
		if (fits) begin
			r.num = nneg ? 32'(-num) : num[31:0];
			r.den = den[30:0];
		end else
			r.st = ST_OVF;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fraction_result_t e;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(predict_fraction(op, a_num, a_den, b_num, b_den));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result num=%0d den=%0d order=%0d status=%0d",
						$time, res_num, res_den, order, status);
					errors <= errors + 1;
				end else begin
					e = expected_results.pop_front();
					if (e.num !== res_num || e.den !== res_den || e.ord !== order
							|| e.st !== status) begin
						$display("%0t: mismatch expected num=%0d den=%0d ord=%0d st=%0d",
							$time, $signed(e.num), e.den, $signed(e.ord), e.st);
						$display("%0t:          actual num=%0d den=%0d ord=%0d st=%0d",
							$time, res_num, res_den, order, status);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_results.size();
		end
	end
endmodule

FILE: bench/tb_rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit_core
// Stimulus and verdict for the rational arithmetic unit: directed corner
// fractions, then random operands under varying sender/receiver idling.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit_core;
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] op;
	logic signed [31:0] a_num, a_den, b_num, b_den;
	logic signed [31:0] res_num;
	logic [30:0] res_den;
	logic signed [1:0] order;
	logic [1:0] status;
	int errors, pending;

	// idling percentages, changed per phase
	int send_idle_pct, recv_idle_pct;
	logic hold_req;		// asks the receiver for one long stall
	logic hold_done;
	int hold_cycles;	// receiver forced-stall length, counted below

	rational_arithmetic_unit_core DUT (.*);

	rau_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, far beyond the end of any correct run
	initial begin
		#1s;
		$display("rational_arithmetic_unit_core test failed");
		$finish;
	end

	// Receiver: random stalls, plus one long hold once hold_req is raised.
	initial begin
		out_ready = 1'b0;
		hold_done = 1'b0;
		hold_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_cycles = 3000;
			end
			if (hold_cycles > 0) begin
				hold_cycles = hold_cycles - 1;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Random field value, biased toward small magnitudes and corners.
	function automatic logic [31:0] pick_field();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			3, 4: return 32'($signed($urandom_range(2000)) - 1000);
			5: return 32'($signed($urandom_range(65536)) - 32768);
			6: return 32'($urandom_range(1)) ? 32'hffff_ffff : 32'd1;
			default: return 32'($signed($urandom_range(40)) - 20);
		endcase
	endfunction

	// Offer one transaction and wait until it is accepted.
	task automatic send_fractions(logic [2:0] o, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random(int count);
		logic [2:0] o;
		logic [31:0] ad, bd;
		repeat (count) begin
			// mostly valid ops and nonzero denominators; a few error cases
			o = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 5))
				: 3'($urandom_range(OP_CMP));
			ad = pick_field();
			bd = pick_field();
			if ($urandom_range(29) != 0 && ad == 0) ad = 32'd7;
			if ($urandom_range(29) != 0 && bd == 0) bd = 32'hffff_fffd;
			send_fractions(o, pick_field(), ad, pick_field(), bd);
		end
		in_valid <= 1'b0;
	endtask

	// one edge first so the checker has seen the last accepted transaction
	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	localparam logic [31:0] MIN_W = 32'h8000_0000;
	localparam logic [31:0] MAX_W = 32'h7fff_ffff;

	initial begin
		in_valid = 1'b0;
		op = OP_ADD;
		a_num = '0; a_den = 32'd1; b_num = '0; b_den = 32'd1;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_fractions(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send_fractions(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);	// zero -> 0/1
		send_fractions(OP_MUL, -32'sd3, 32'd4, 32'd8, -32'sd9);
		send_fractions(OP_DIV, 32'd3, -32'sd4, -32'sd9, 32'd8);
		send_fractions(OP_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
		send_fractions(OP_CMP, 32'd2, 32'd4, -32'sd1, -32'sd2);	// equal
		send_fractions(OP_CMP, MAX_W, 32'd1, MIN_W, 32'd1);
		send_fractions(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);	// zero denominator
		send_fractions(OP_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
		send_fractions(OP_DIV, 32'd5, 32'd1, 32'd0, 32'd7);	// divide by zero
		send_fractions(3'd5, 32'd1, 32'd1, 32'd1, 32'd1);	// invalid ops
		send_fractions(3'd6, 32'd1, 32'd1, 32'd1, 32'd1);
		send_fractions(3'd7, 32'd1, 32'd1, 32'd1, 32'd1);
		send_fractions(OP_MUL, MIN_W, 32'd1, MIN_W, 32'd1);	// overflow
		send_fractions(OP_MUL, MIN_W, 32'd1, -32'sd1, 32'd1);	// +2^31 overflows
		send_fractions(OP_DIV, MIN_W, 32'd1, 32'd1, 32'd1);	// exact min word fits
		send_fractions(OP_ADD, MAX_W, 32'd1, MAX_W, 32'd1);
		send_fractions(OP_SUB, MIN_W, MAX_W, MAX_W, MIN_W);
		send_fractions(OP_DIV, 32'd1, MIN_W, 32'd1, 32'd1);	// den 2^31 overflows
		send_fractions(OP_MUL, 32'd1, MIN_W, -32'sd1, 32'd1);
		send_fractions(OP_ADD, 32'd1, MAX_W, 32'd1, 32'h7fff_fffe);
		send_fractions(OP_CMP, 32'hffff_ffff, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
		in_valid <= 1'b0;
		drain();

		// long receiver hold while the sender keeps offering
		hold_req = 1'b1;
		send_random(8);
		drain();

		send_idle_pct = 19; recv_idle_pct = 47;
		send_random(375);
		drain();	// sender pauses until everything is back
		send_idle_pct = 47; recv_idle_pct = 19;
		send_random(375);
		send_idle_pct = 0; recv_idle_pct = 0;
		send_random(375);
		drain();
		repeat (100) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("rational_arithmetic_unit_core test passed");
		else
			$display("rational_arithmetic_unit_core test failed");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rau_pkg.sv
rtl/core/rau_divider.sv
rtl/core/rational_arithmetic_unit_core.sv
bench/rau_checker.sv
bench/tb_rational_arithmetic_unit_core.sv
